// File: src/ofr_pkg.sv
// Shared types, codes and constants for the overlap-add ring framer.
`timescale 1ns / 1ps
package ofr_pkg;

	localparam int DEF_RING_DEPTH   = 1024;
	localparam int DEF_SAMPLE_BITS  = 24;

	localparam int OPCODE_BITS      = 3;
	localparam int IO_SAMPLE_BITS   = 24;
	localparam int OFFSET_BITS      = 10;
	localparam int COUNT_FIELD_BITS = 11;
	localparam int STATUS_BITS      = 2;

	localparam int CFG_INDEX_BITS   = 1;
	localparam int CFG_DATA_BITS    = 11;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HOP_LENGTH   = 1'b1;

	localparam logic [CFG_DATA_BITS-1:0] FRAME_LENGTH_RESET = 11'd512;
	localparam logic [CFG_DATA_BITS-1:0] HOP_LENGTH_RESET   = 11'd256;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_WRITE   = 3'd0,
		OP_POP     = 3'd1,
		OP_PEEK    = 3'd2,
		OP_CONSUME = 3'd3,
		OP_OADD    = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// memory work that an accepted transaction leaves for the second stage
	typedef enum logic [1:0] {
		K_NONE  = 2'd0,
		K_READ  = 2'd1,
		K_WRITE = 2'd2,
		K_OADD  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [OPCODE_BITS-1:0]           opcode;
		logic signed [IO_SAMPLE_BITS-1:0] sample_in;
		logic [OFFSET_BITS-1:0]           frame_offset;
	} in_item_t;

	typedef struct packed {
		logic signed [IO_SAMPLE_BITS-1:0] sample_out;
		logic [COUNT_FIELD_BITS-1:0]      fill_count;
		logic [COUNT_FIELD_BITS-1:0]      free_count;
		logic [STATUS_BITS-1:0]           status;
	} out_item_t;

	typedef struct packed {
		kind_t                       kind;
		status_t                     status;
		logic [COUNT_FIELD_BITS-1:0] fill;
		logic [COUNT_FIELD_BITS-1:0] free;
	} issue_t;

endpackage

// File: src/ofr_ring_mem.sv
// Sample store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module ofr_ring_mem #(
	parameter int DEPTH = ofr_pkg::DEF_RING_DEPTH,
	parameter int WIDTH = ofr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	import ofr_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents when the same entry is written at this edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/ofr_ctrl.sv
// Configuration registers, ring pointers, fill count and per-operation decisions.
`timescale 1ns / 1ps
module ofr_ctrl #(
	parameter int RING_DEPTH = ofr_pkg::DEF_RING_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [ofr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [ofr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic                                accept,
	input  ofr_pkg::in_item_t                   item,
	output ofr_pkg::issue_t                     issue,
	output logic [$clog2(RING_DEPTH)-1:0]       addr
);
	import ofr_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int CMP_W = ((CNT_W > CFG_DATA_BITS) ? CNT_W : CFG_DATA_BITS) + 1;
	localparam int SUM_W = ((PTR_W > CFG_DATA_BITS) ? PTR_W : CFG_DATA_BITS) + 1;
	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(RING_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

	logic [CFG_DATA_BITS-1:0] frame_len_q;
	logic [CFG_DATA_BITS-1:0] hop_len_q;
	logic [PTR_W-1:0]         rp_q;
	logic [PTR_W-1:0]         wp_q;
	logic [CNT_W-1:0]         cnt_q;

	logic [PTR_W-1:0] rp_d;
	logic [PTR_W-1:0] wp_d;
	logic [CNT_W-1:0] cnt_d;
	logic [SUM_W-1:0] addr_sum;
	logic [SUM_W-1:0] hop_sum;
	logic [CMP_W-1:0] off_c;
	logic [CMP_W-1:0] fl_c;
	logic [CMP_W-1:0] hop_c;
	logic [CMP_W-1:0] cnt_c;
	logic [CMP_W-1:0] dist_c;
	logic [SUM_W-1:0] dist_s;
	logic [CMP_W-1:0] fill_w;
	logic [CMP_W-1:0] free_w;
	kind_t            kind;
	status_t          st;

	// sums stay below twice the depth whenever the operation is allowed
	function automatic logic [SUM_W-1:0] wrap(input logic [SUM_W-1:0] s);
		return (s >= DEPTH_S) ? s - DEPTH_S : s;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		rp_d     = rp_q;
		wp_d     = wp_q;
		cnt_d    = cnt_q;
		kind     = K_NONE;
		st       = ST_OK;
		addr_sum = '0;
		off_c    = CMP_W'(item.frame_offset);
		fl_c     = CMP_W'(frame_len_q);
		hop_c    = CMP_W'(hop_len_q);
		cnt_c    = CMP_W'(cnt_q);
		dist_c   = fl_c - off_c;
		dist_s   = dist_c[SUM_W-1:0];
		hop_sum  = wrap(SUM_W'(rp_q) + SUM_W'(hop_len_q));
		unique case (item.opcode)
			OP_WRITE: begin
				if (cnt_q == CNT_FULL) begin
					st = ST_OVERFLOW;
				end else begin
					kind     = K_WRITE;
					addr_sum = SUM_W'(wp_q);
					wp_d     = ptr_inc(wp_q);
					cnt_d    = cnt_q + 1'b1;
				end
			end
			OP_POP: begin
				if (cnt_q == '0) begin
					st = ST_UNDERFLOW;
				end else begin
					kind     = K_READ;
					addr_sum = SUM_W'(rp_q);
					rp_d     = ptr_inc(rp_q);
					cnt_d    = cnt_q - 1'b1;
				end
			end
			OP_PEEK: begin
				if (off_c < fl_c && off_c < cnt_c) begin
					kind     = K_READ;
					addr_sum = wrap(SUM_W'(rp_q) + SUM_W'(item.frame_offset));
				end else begin
					st = ST_RANGE;
				end
			end
			OP_CONSUME: begin
				if (hop_c > cnt_c) begin
					st = ST_UNDERFLOW;
				end else begin
					rp_d  = hop_sum[PTR_W-1:0];
					cnt_d = CNT_W'(cnt_c - hop_c);
				end
			end
			OP_OADD: begin
				if (off_c < fl_c && dist_c <= cnt_c) begin
					kind = K_OADD;
					if (SUM_W'(wp_q) >= dist_s) begin
						addr_sum = SUM_W'(wp_q) - dist_s;
					end else begin
						addr_sum = SUM_W'(wp_q) + DEPTH_S - dist_s;
					end
				end else begin
					st = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		fill_w = CMP_W'(cnt_d);
		free_w = CMP_W'(RING_DEPTH) - fill_w;
	end

	assign addr         = addr_sum[PTR_W-1:0];
	assign issue.kind   = kind;
	assign issue.status = st;
	assign issue.fill   = fill_w[COUNT_FIELD_BITS-1:0];
	assign issue.free   = free_w[COUNT_FIELD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= FRAME_LENGTH_RESET;
			hop_len_q   <= HOP_LENGTH_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FRAME_LENGTH: frame_len_q <= cfg_wdata;
				REG_HOP_LENGTH:   hop_len_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			rp_q  <= rp_d;
			wp_q  <= wp_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// File: src/ofr_datapath.sv
// Second stage: forwarding, saturating arithmetic, write-back and output register.
`timescale 1ns / 1ps
module ofr_datapath #(
	parameter int RING_DEPTH  = ofr_pkg::DEF_RING_DEPTH,
	parameter int SAMPLE_BITS = ofr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  ofr_pkg::issue_t                         issue,
	input  logic [$clog2(RING_DEPTH)-1:0]           addr,
	input  logic signed [ofr_pkg::IO_SAMPLE_BITS-1:0] sample_in,
	input  logic [SAMPLE_BITS-1:0]                  rdata,
	output logic                                    mem_we,
	output logic [$clog2(RING_DEPTH)-1:0]           mem_waddr,
	output logic [SAMPLE_BITS-1:0]                  mem_wdata,
	output logic                                    in_ready,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output ofr_pkg::out_item_t                      out_data
);
	import ofr_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int WB = ((SAMPLE_BITS > IO_SAMPLE_BITS) ? SAMPLE_BITS : IO_SAMPLE_BITS) + 1;
	localparam longint S_HI_L  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint IO_HI_L = (longint'(1) << (IO_SAMPLE_BITS - 1)) - 1;
	localparam logic signed [WB-1:0] S_HI  = WB'(S_HI_L);
	localparam logic signed [WB-1:0] S_LO  = WB'(-S_HI_L - 1);
	localparam logic signed [WB-1:0] IO_HI = WB'(IO_HI_L);
	localparam logic signed [WB-1:0] IO_LO = WB'(-IO_HI_L - 1);

	logic                             valid_s1;
	issue_t                           issue_s1;
	logic [PTR_W-1:0]                 addr_s1;
	logic signed [IO_SAMPLE_BITS-1:0] sample_s1;
	logic                             fwd_s1;
	logic [SAMPLE_BITS-1:0]           fwd_data_s1;
	logic                             out_valid_q;
	out_item_t                        out_q;

	logic                             advance;
	logic signed [SAMPLE_BITS-1:0]    stored;
	logic signed [WB-1:0]             sum_w;
	logic signed [WB-1:0]             wr_w;
	logic signed [WB-1:0]             rd_w;
	logic [SAMPLE_BITS-1:0]           wdata;
	logic signed [IO_SAMPLE_BITS-1:0] sample_rd;

	function automatic logic signed [WB-1:0] sat(
		input logic signed [WB-1:0] v,
		input logic signed [WB-1:0] hi,
		input logic signed [WB-1:0] lo
	);
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// the entry written back this cycle is read stale by a transaction accepted now
	assign stored = fwd_s1 ? fwd_data_s1 : rdata;

	always_comb begin
		sum_w = WB'(stored) + WB'(sample_s1);
		if (issue_s1.kind == K_OADD) begin
			wr_w = sat(sum_w, S_HI, S_LO);
		end else begin
			wr_w = sat(WB'(sample_s1), S_HI, S_LO);
		end
		wdata = wr_w[SAMPLE_BITS-1:0];
		rd_w  = sat(WB'(stored), IO_HI, IO_LO);
		if (issue_s1.kind == K_READ) begin
			sample_rd = rd_w[IO_SAMPLE_BITS-1:0];
		end else begin
			sample_rd = '0;
		end
	end

	assign mem_we    = advance && (issue_s1.kind == K_WRITE || issue_s1.kind == K_OADD);
	assign mem_waddr = addr_s1;
	assign mem_wdata = wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			issue_s1    <= issue;
			addr_s1     <= addr;
			sample_s1   <= sample_in;
			fwd_s1      <= mem_we && (mem_waddr == addr);
			fwd_data_s1 <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.sample_out <= sample_rd;
			out_q.fill_count <= issue_s1.fill;
			out_q.free_count <= issue_s1.free;
			out_q.status     <= issue_s1.status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/overlap_add_ring_framer.sv
// Top level of the overlap-add ring framer for short-time Fourier framing.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  cfg     | in        | cfg_wen               | cfg_index, cfg_wdata (frame, hop length)
//  in      | in        | in_valid / in_ready   | in_data: opcode, sample_in, frame_offset
//  out     | out       | out_valid / out_ready | out_data: sample_out, fill/free, status
//
//  One transaction per cycle sustained while the output is not stalled; a result
//  passes the second stage and then the output register after its transaction is
//  accepted. The second stage waits for the sample store's registered read data.
//  Reset (arst_n low) clears pointers, fill count and pipeline valids and loads
//  the register defaults; the sample store is not cleared and needs no sweep.
//  A stalled output holds its result; one more transaction is taken into the
//  second stage, then in_ready drops until the output drains.
//
//  Pointer, count and status decisions are made at accept time, since they never
//  depend on stored samples. The second stage finishes the memory work: pops and
//  peeks return the registered read, writes and overlap-adds write back. A
//  write-back forwards its write data to a transaction accepted in the same cycle
//  that reads the same entry.
module overlap_add_ring_framer #(
	parameter int RING_DEPTH  = ofr_pkg::DEF_RING_DEPTH,
	parameter int SAMPLE_BITS = ofr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [ofr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ofr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ofr_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ofr_pkg::out_item_t                 out_data
);
	import ofr_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);

	logic                   accept;
	issue_t                 issue;
	logic [PTR_W-1:0]       addr;
	logic                   mem_re;
	logic                   mem_we;
	logic [PTR_W-1:0]       mem_waddr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic [SAMPLE_BITS-1:0] mem_rdata;

	assign accept = in_valid && in_ready;

	// issue a read only for transactions that consume stored data
	assign mem_re = accept && (issue.kind == K_READ || issue.kind == K_OADD);

	ofr_ctrl #(
		.RING_DEPTH(RING_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (in_data),
		.issue     (issue),
		.addr      (addr)
	);

	ofr_ring_mem #(
		.DEPTH(RING_DEPTH),
		.WIDTH(SAMPLE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr),
		.rdata (mem_rdata)
	);

	ofr_datapath #(
		.RING_DEPTH (RING_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.issue     (issue),
		.addr      (addr),
		.sample_in (in_data.sample_in),
		.rdata     (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: tb/sv/overlap_add_ring_framer_test.sv
// Self-checking testbench for the overlap-add ring framer: directed and random operations.
`timescale 1ns / 1ps
module overlap_add_ring_framer_test;
	import ofr_pkg::*;

	localparam int RING_DEPTH = DEF_RING_DEPTH;

	// Sample range of the ring and of the output field (both 24 bits wide here).
	localparam logic signed [IO_SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(IO_SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [IO_SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(IO_SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [IO_SAMPLE_BITS-1:0] SAMPLE_ONES = '1;

	// Opcodes above the last defined one are ignored by the block.
	localparam logic [OPCODE_BITS-1:0] OP_FIRST_UNUSED = OP_OADD + 1'b1;
	localparam logic [OPCODE_BITS-1:0] OP_LAST_CODE    = '1;

	// Cycles without any transaction on either channel before the run is abandoned.
	// The longest legitimate quiet stretch is a register write pause; random
	// stalls at 80 percent never come close.
	localparam int unsigned QUIET_LIMIT = 2000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wen = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;

	overlap_add_ring_framer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Ring image: our own copy of the block's state and registers.
	// ---------------------------------------------------------------------
	logic signed [IO_SAMPLE_BITS-1:0] ring_image [RING_DEPTH];
	int unsigned ring_rp = 0;
	int unsigned ring_wp = 0;
	int unsigned ring_fill = 0;
	int unsigned frame_len = FRAME_LENGTH_RESET;
	int unsigned hop_len = HOP_LENGTH_RESET;

	// Results that accepted operations still owe, oldest first.
	out_item_t due_results [$];

	// Apply one operation to the ring image and return the result it produces.
	function automatic out_item_t advance_ring(in_item_t t);
		out_item_t   r;
		int unsigned off;
		int unsigned idx;
		int          acc;
		r = '0;
		r.status = ST_OK;
		off = t.frame_offset;
		case (t.opcode)
		OP_WRITE: begin
			if (ring_fill >= RING_DEPTH) begin
				r.status = ST_OVERFLOW;
			end else begin
				ring_image[ring_wp] = t.sample_in;
				ring_wp = (ring_wp + 1) % RING_DEPTH;
				ring_fill++;
			end
		end
		OP_POP: begin
			if (ring_fill == 0) begin
				r.status = ST_UNDERFLOW;
			end else begin
				r.sample_out = ring_image[ring_rp];
				ring_rp = (ring_rp + 1) % RING_DEPTH;
				ring_fill--;
			end
		end
		OP_PEEK: begin
			if (off < frame_len && off < ring_fill) begin
				r.sample_out = ring_image[(ring_rp + off) % RING_DEPTH];
			end else begin
				r.status = ST_RANGE;
			end
		end
		OP_CONSUME: begin
			// a hop of zero is a legal no-op
			if (hop_len > ring_fill) begin
				r.status = ST_UNDERFLOW;
			end else begin
				ring_rp = (ring_rp + hop_len) % RING_DEPTH;
				ring_fill -= hop_len;
			end
		end
		OP_OADD: begin
			// target sits frame_len - off entries below the write pointer
			if (off < frame_len && frame_len - off <= ring_fill) begin
				idx = (ring_wp + RING_DEPTH - (frame_len - off)) % RING_DEPTH;
				acc = int'(ring_image[idx]) + int'($signed(t.sample_in));
				if (acc > int'(SAMPLE_MAX)) acc = int'(SAMPLE_MAX);
				if (acc < int'(SAMPLE_MIN)) acc = int'(SAMPLE_MIN);
				ring_image[idx] = IO_SAMPLE_BITS'(acc);
			end else begin
				r.status = ST_RANGE;
			end
		end
		default: begin
		end
		endcase
		r.fill_count = COUNT_FIELD_BITS'(ring_fill);
		r.free_count = COUNT_FIELD_BITS'(RING_DEPTH - ring_fill);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Operation queue and planning. The planner tracks the fill level only,
	// which never depends on sample data, to aim offsets at the filled region.
	// ---------------------------------------------------------------------
	typedef struct packed {
		logic     hold;   // hold off until every owed result has arrived
		in_item_t item;
	} pending_op_t;

	pending_op_t pending_ops [$];
	int unsigned queued_ops = 0;
	int unsigned plan_fill = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	function automatic logic [IO_SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
		0: return SAMPLE_MAX;
		1: return SAMPLE_MIN;
		2: return '0;
		3: return SAMPLE_ONES;
		default: return IO_SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic queue_op(logic [OPCODE_BITS-1:0] op, logic [IO_SAMPLE_BITS-1:0] s,
			logic [OFFSET_BITS-1:0] off, logic hold);
		pending_op_t p;
		p.hold = hold;
		p.item.opcode = op;
		p.item.sample_in = s;
		p.item.frame_offset = off;
		pending_ops.push_back(p);
		queued_ops++;
		case (op)
		OP_WRITE: if (plan_fill < RING_DEPTH) plan_fill++;
		OP_POP: if (plan_fill > 0) plan_fill--;
		OP_CONSUME: if (hop_len <= plan_fill) plan_fill -= hop_len;
		default: begin
		end
		endcase
	endtask

	// Mostly well-formed traffic: peeks and overlap-adds land inside the
	// filled frame four times in five, the rest take raw random offsets.
	task automatic random_ops(int n);
		int unsigned            w;
		int unsigned            span;
		logic [OFFSET_BITS-1:0] off;
		for (int i = 0; i < n; i++) begin
			w = $urandom_range(99);
			span = (plan_fill < frame_len) ? plan_fill : frame_len;
			off = OFFSET_BITS'($urandom);
			if (w < 35) begin
				queue_op(OP_WRITE, pick_sample(), off, 1'b0);
			end else if (w < 50) begin
				queue_op(OP_POP, pick_sample(), off, 1'b0);
			end else if (w < 68) begin
				if (span > 0 && $urandom_range(4) != 0) off = OFFSET_BITS'($urandom_range(span - 1));
				queue_op(OP_PEEK, pick_sample(), off, 1'b0);
			end else if (w < 78) begin
				queue_op(OP_CONSUME, pick_sample(), off, 1'b0);
			end else if (w < 95) begin
				if (span > 0 && $urandom_range(4) != 0)
					off = OFFSET_BITS'(frame_len - 1 - $urandom_range(span - 1));
				queue_op(OP_OADD, pick_sample(), off, 1'b0);
			end else begin
				queue_op(OPCODE_BITS'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE)),
					pick_sample(), off, 1'b0);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: present queued operations, predict each one on acceptance.
	// Counters shared with other processes move by nonblocking assignment so
	// every reader at an edge sees the same value.
	// ---------------------------------------------------------------------
	int unsigned accepted_ops = 0;
	int unsigned results_seen = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				due_results.push_back(advance_ring(in_data));
				accepted_ops <= accepted_ops + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct
						&& !(pending_ops[0].hold && (in_valid || results_seen != accepted_ops))) begin
					in_data <= pending_ops[0].item;
					in_valid <= 1'b1;
					void'(pending_ops.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: compare each result transaction with the oldest owed result.
	// ---------------------------------------------------------------------
	int unsigned error_count = 0;

	function automatic void log_error(string msg);
		if (error_count < 10) $display("%0t: %s", $realtime, msg);
		error_count++;
	endfunction

	always @(posedge clk) begin : result_monitor
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					log_error($sformatf("result with nothing owed: sample %0d fill %0d free %0d status %0d",
						$signed(out_data.sample_out), out_data.fill_count, out_data.free_count,
						out_data.status));
				end else begin
					want = due_results.pop_front();
					if (out_data.sample_out !== want.sample_out || out_data.fill_count !== want.fill_count
							|| out_data.free_count !== want.free_count
							|| out_data.status !== want.status) begin
						log_error($sformatf({"result mismatch: expected sample %0d fill %0d free %0d ",
							"status %0d, got sample %0d fill %0d free %0d status %0d"},
							$signed(want.sample_out), want.fill_count, want.free_count, want.status,
							$signed(out_data.sample_out), out_data.fill_count, out_data.free_count,
							out_data.status));
					end
					results_seen <= results_seen + 1;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: abandon the run when no transaction moves for too long.
	// ---------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------

	// Write one register; only called while the block is idle. Ends on a
	// falling edge so that later queue updates never race the driver.
	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_BITS'(val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_FRAME_LENGTH) frame_len = val;
		else hop_len = val;
		@(negedge clk);
	endtask

	// Wait for every queued operation to be accepted and answered, then let
	// the two-stage pipeline settle.
	task automatic wait_idle();
		while (accepted_ops != queued_ops || results_seen != accepted_ops) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Phase 1: reset registers (frame 512, hop 256), slow receiver.
		send_idle_pct = 27;
		recv_stall_pct = 80;
		// empty ring: every read-type operation is refused
		queue_op(OP_POP, '0, '0, 1'b0);
		queue_op(OP_CONSUME, '0, '0, 1'b0);
		queue_op(OP_PEEK, '0, '0, 1'b0);
		queue_op(OP_OADD, SAMPLE_MAX, '0, 1'b0);
		// opcodes past the defined set change nothing
		for (int k = 0; k < 3; k++)
			queue_op(OP_FIRST_UNUSED + OPCODE_BITS'(k), pick_sample(), OFFSET_BITS'($urandom), 1'b0);
		// extremes, zero padding and minus one
		queue_op(OP_WRITE, SAMPLE_MAX, '0, 1'b0);
		queue_op(OP_WRITE, SAMPLE_MIN, '0, 1'b0);
		queue_op(OP_WRITE, '0, '0, 1'b0);
		queue_op(OP_WRITE, SAMPLE_ONES, '0, 1'b0);
		queue_op(OP_PEEK, '0, 10'd0, 1'b0);
		queue_op(OP_PEEK, '0, 10'd3, 1'b0);
		queue_op(OP_PEEK, '0, '1, 1'b0);
		// overlap-add saturating both ways, each followed at once by a read of
		// the same entry to exercise the write-back forwarding
		queue_op(OP_OADD, SAMPLE_MAX, 10'd508, 1'b0);
		queue_op(OP_PEEK, '0, 10'd0, 1'b0);
		queue_op(OP_OADD, SAMPLE_MIN, 10'd509, 1'b0);
		queue_op(OP_PEEK, '0, 10'd1, 1'b0);
		queue_op(OP_OADD, 24'sd5, 10'd511, 1'b0);
		// target one below the filled region
		queue_op(OP_OADD, 24'sd5, 10'd507, 1'b0);
		queue_op(OP_POP, '0, '0, 1'b0);
		queue_op(OP_POP, '0, '0, 1'b0);
		random_ops(60);
		wait_idle();

		// Phase 2: frame length zero refuses all offsets; hop of zero succeeds.
		write_reg(REG_FRAME_LENGTH, 0);
		write_reg(REG_HOP_LENGTH, 0);
		queue_op(OP_PEEK, '0, '0, 1'b0);
		queue_op(OP_OADD, SAMPLE_MAX, '0, 1'b0);
		queue_op(OP_CONSUME, '0, '0, 1'b0);
		queue_op(OP_WRITE, pick_sample(), '0, 1'b0);
		queue_op(OP_PEEK, '0, '1, 1'b0);
		queue_op(OP_OADD, SAMPLE_MIN, '1, 1'b0);
		wait_idle();

		// Phase 3: smallest frame and hop, slow sender.
		write_reg(REG_FRAME_LENGTH, 1);
		write_reg(REG_HOP_LENGTH, 1);
		send_idle_pct = 80;
		recv_stall_pct = 27;
		random_ops(70);
		wait_idle();

		// Phase 4: short frames with a mid-stream pause until every owed result has arrived.
		write_reg(REG_FRAME_LENGTH, 16);
		write_reg(REG_HOP_LENGTH, 8);
		random_ops(60);
		queue_op(OP_PEEK, '0, '0, 1'b1);
		random_ops(60);
		wait_idle();

		// Phase 5: largest frame and hop over a partly filled ring, no idling.
		write_reg(REG_FRAME_LENGTH, RING_DEPTH);
		write_reg(REG_HOP_LENGTH, RING_DEPTH);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (plan_fill < 32) queue_op(OP_WRITE, pick_sample(), OFFSET_BITS'($urandom), 1'b0);
		queue_op(OP_PEEK, '0, '1, 1'b0);           // past the filled region
		queue_op(OP_PEEK, '0, '0, 1'b0);
		queue_op(OP_OADD, SAMPLE_MAX, '0, 1'b0);   // a whole frame below, refused
		queue_op(OP_OADD, SAMPLE_MIN, '1, 1'b0);   // newest entry
		queue_op(OP_POP, '0, '0, 1'b0);
		queue_op(OP_CONSUME, '0, '0, 1'b0);        // hop longer than the fill
		random_ops(40);
		wait_idle();

		// Phase 6: odd frame and hop sizes, still no idling.
		write_reg(REG_FRAME_LENGTH, 7);
		write_reg(REG_HOP_LENGTH, 3);
		random_ops(70);
		wait_idle();

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: files.f
src/ofr_pkg.sv
src/ofr_ring_mem.sv
src/ofr_ctrl.sv
src/ofr_datapath.sv
src/overlap_add_ring_framer.sv
tb/sv/overlap_add_ring_framer_test.sv
